FILE: design/lhr_pkg.sv
// Package for line_history_ring: operation codes and the controller state type.
// No dependencies.
package lhr_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_OLDER = 2'd1,
    OP_NEWER = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NONE,
    S_LEN_RD,
    S_LEN,
    S_EMIT_RD,
    S_EMIT,
    S_CMP_LEN,
    S_CMP_RD,
    S_CMP_CHK,
    S_COPY_RD,
    S_COPY_WR
  } state_t;

endpackage

FILE: design/line_history_ring.sv
// line_history_ring: ring of recent text lines held in block memories, with a staging buffer.
// Depends on lhr_pkg.
//
//  channel | dir | beat contents
//  s_*     | in  | tuser[1:0] op, tdata[7:0] ch
//  m_*     | out | tuser[0] found, tdata[7:0] ch_res, tlast last
//
// A non-zero add byte is staged in the idle state, or sets the overflow flag once the line is
// full. A terminator compares the line byte by byte with the newest entry, then, unless it is a
// duplicate, copies it byte by byte into the ring; both use the staging read port, the compare
// also the history read port. Older/newer: a length lookup, then a history read per entry byte.
// rst clears the control state; the memories hold nothing meaningful until written.
// Output stalls hold the sequencer; one finished beat may wait while the next is accepted.
module line_history_ring #(
  parameter int HISTORY_DEPTH = 32,
  parameter int LINE_BYTES    = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [1:0] s_tuser,   // [1:0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] ch_res
  output logic [0:0] m_tuser,   // [0] found
  output logic       m_tlast
);
  import lhr_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int TW = CW + 1;
  localparam int LW = $clog2(LINE_BYTES);
  localparam int HD = HISTORY_DEPTH << LW;

  state_t state, state_next;
  logic [LW-1:0] staged_len, staged_len_next;
  logic          staged_ovf, staged_ovf_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] nav, nav_next;
  logic [LW-1:0] idx, idx_next;
  logic [AW-1:0] slot, slot_next;

  logic       out_valid, out_found, out_last;
  logic [7:0] out_ch;
  logic       out_load, out_found_next, out_last_next;
  logic [7:0] out_ch_next;
  logic       out_free;

  logic [7:0]    st_mem [LINE_BYTES];
  logic [7:0]    st_rdata;
  logic          st_we, st_re;

  logic [7:0]    hist_mem [HD];
  logic [7:0]    hist_rdata;
  logic          hist_we, hist_re;

  logic [LW-1:0] el_mem [HISTORY_DEPTH];
  logic [LW-1:0] el_rdata;
  logic          el_we, el_re;
  logic [AW-1:0] el_raddr;

  logic          accept;
  op_t           op;
  logic [AW-1:0] prev_slot, head_inc, nav_slot;
  logic [TW-1:0] slot_sum;
  logic [LW-1:0] idx_inc;

  assign accept    = s_tvalid && s_tready;
  assign op        = op_t'(s_tuser);
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !out_valid || m_tready;
  assign idx_inc   = idx + LW'(1);
  assign prev_slot = (head == '0) ? AW'(HISTORY_DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + AW'(1);
  assign slot_sum  = TW'(head) + TW'(HISTORY_DEPTH) - TW'(nav);
  assign nav_slot  = (slot_sum >= TW'(HISTORY_DEPTH)) ? AW'(slot_sum - TW'(HISTORY_DEPTH))
                                                      : AW'(slot_sum);

  always_comb begin
    state_next      = state;
    staged_len_next = staged_len;
    staged_ovf_next = staged_ovf;
    head_next       = head;
    count_next      = count;
    nav_next        = nav;
    idx_next        = idx;
    slot_next       = slot;
    st_we           = 1'b0;
    st_re           = 1'b0;
    hist_we         = 1'b0;
    hist_re         = 1'b0;
    el_we           = 1'b0;
    el_re           = 1'b0;
    el_raddr        = prev_slot;
    out_load        = 1'b0;
    out_found_next  = 1'b0;
    out_ch_next     = '0;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ADD: begin
              if (s_tdata != 8'd0) begin
                if (staged_len < LW'(LINE_BYTES - 1)) begin
                  st_we           = 1'b1;
                  staged_len_next = staged_len + LW'(1);
                end else begin
                  staged_ovf_next = 1'b1;
                end
              end else if (staged_len == '0) begin
                staged_ovf_next = 1'b0;
              end else if (count == '0 || staged_ovf) begin
                idx_next   = '0;
                state_next = S_COPY_RD;
              end else begin
                el_re      = 1'b1;
                slot_next  = prev_slot;
                state_next = S_CMP_LEN;
              end
            end
            OP_OLDER: begin
              if (nav >= count) begin
                state_next = S_NONE;
              end else begin
                nav_next   = nav + CW'(1);
                state_next = S_LEN_RD;
              end
            end
            OP_NEWER: begin
              nav_next = (nav == '0) ? nav : nav - CW'(1);
              if (nav == '0 || nav == CW'(1)) begin
                state_next = S_NONE;
              end else begin
                state_next = S_LEN_RD;
              end
            end
            default: nav_next = '0;
          endcase
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LEN_RD: begin
        el_re      = 1'b1;
        el_raddr   = nav_slot;
        slot_next  = nav_slot;
        state_next = S_LEN;
      end
      S_LEN: begin
        idx_next   = '0;
        state_next = (el_rdata == '0) ? S_NONE : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        hist_re    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_found_next = 1'b1;
          out_ch_next    = hist_rdata;
          out_last_next  = (idx_inc == el_rdata);
          idx_next       = idx_inc;
          state_next     = (idx_inc == el_rdata) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_CMP_LEN: begin
        idx_next   = '0;
        state_next = (el_rdata == staged_len) ? S_CMP_RD : S_COPY_RD;
      end
      S_CMP_RD: begin
        st_re      = 1'b1;
        hist_re    = 1'b1;
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (st_rdata != hist_rdata) begin
          idx_next   = '0;
          state_next = S_COPY_RD;
        end else if (idx_inc == staged_len) begin
          // duplicate of the newest entry: drop it
          staged_len_next = '0;
          staged_ovf_next = 1'b0;
          state_next      = S_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_CMP_RD;
        end
      end
      S_COPY_RD: begin
        st_re      = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        hist_we = 1'b1;
        if (idx_inc == staged_len) begin
          el_we           = 1'b1;
          head_next       = head_inc;
          count_next      = (count == CW'(HISTORY_DEPTH)) ? count : count + CW'(1);
          nav_next        = '0;
          staged_len_next = '0;
          staged_ovf_next = 1'b0;
          state_next      = S_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_COPY_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      staged_len <= '0;
      staged_ovf <= 1'b0;
      head       <= '0;
      count      <= '0;
      nav        <= '0;
      idx        <= '0;
      slot       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      staged_len <= staged_len_next;
      staged_ovf <= staged_ovf_next;
      head       <= head_next;
      count      <= count_next;
      nav        <= nav_next;
      idx        <= idx_next;
      slot       <= slot_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= out_found_next;
      out_ch    <= out_ch_next;
      out_last  <= out_last_next;
    end
  end

  // staging buffer
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[staged_len] <= s_tdata;
    end
    if (st_re) begin
      st_rdata <= st_mem[idx];
    end
  end

  // entry text, one row of 2**LW bytes per slot
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[{head, idx}] <= st_rdata;
    end
    if (hist_re) begin
      hist_rdata <= hist_mem[{slot, idx}];
    end
  end

  // entry lengths
  always_ff @(posedge clk) begin
    if (el_we) begin
      el_mem[head] <= staged_len;
    end
    if (el_re) begin
      el_rdata <= el_mem[el_raddr];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_ch;
  assign m_tuser  = out_found;
  assign m_tlast  = out_last;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for line_history_ring: adds, duplicate and overlong lines,
// older/newer walks through the ring. Random stalls on both stream sides.
// Depends on lhr_pkg and the line_history_ring RTL.
module tb;
  import lhr_pkg::*;

  localparam int HIST  = 32;
  localparam int LINE  = 64;
  localparam int LIMIT = 5_000_000;

  typedef struct packed {
    logic       found;
    logic [7:0] ch;
    logic       last;
  } result_t;

  class history_scoreboard;
    bit [7:0]    text [HIST][LINE];
    bit [5:0]    elen [HIST];
    bit [7:0]    stage [LINE];
    int unsigned stage_len, head, count, nav;
    bit          stage_ovf;
    result_t     pending_q[$];
    int          errors, n_checked, n_lines, n_dups;

    function int pending();
      return pending_q.size();
    endfunction

    function void push_none();
      result_t r;
      r.found = 1'b0;
      r.ch    = 8'h00;
      r.last  = 1'b1;
      pending_q.push_back(r);
    endfunction

    function void push_entry();
      int unsigned slot, len;
      result_t     r;
      slot = (head + HIST - nav % HIST) % HIST;
      len  = elen[slot];
      if (len == 0) begin
        push_none();
        return;
      end
      for (int i = 0; i < len; i++) begin
        r.found = 1'b1;
        r.ch    = text[slot][i];
        r.last  = (i + 1 == len);
        pending_q.push_back(r);
      end
    endfunction

    function void close_line();
      int unsigned len, prev;
      bit          ovf, same;
      len = stage_len;
      ovf = stage_ovf;
      stage_len = 0;
      stage_ovf = 1'b0;
      if (len == 0) return;
      if (count > 0 && !ovf) begin
        prev = (head + HIST - 1) % HIST;
        same = (elen[prev] == len);
        for (int i = 0; i < len; i++)
          if (text[prev][i] != stage[i]) same = 1'b0;
        if (same) begin
          n_dups++;
          return;
        end
      end
      for (int i = 0; i < len; i++) text[head][i] = stage[i];
      elen[head] = len;
      head = (head + 1) % HIST;
      if (count < HIST) count++;
      nav = 0;
      n_lines++;
    endfunction

    function void predict_beat(op_t op, logic [7:0] ch);
      case (op)
        OP_ADD: begin
          if (ch != 8'h00) begin
            if (stage_len < LINE - 1) begin
              stage[stage_len] = ch;
              stage_len++;
            end else begin
              stage_ovf = 1'b1;
            end
          end else begin
            close_line();
          end
        end
        OP_OLDER: begin
          if (nav >= count) begin
            push_none();
          end else begin
            nav++;
            push_entry();
          end
        end
        OP_NEWER: begin
          if (nav == 0) begin
            push_none();
          end else begin
            nav--;
            if (nav == 0) push_none();
            else push_entry();
          end
        end
        default: nav = 0;
      endcase
    endfunction

    function void check_beat(logic found, logic [7:0] ch, logic last);
      result_t want;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: found=%0d ch_res=%02h last=%0d",
               found, ch, last);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (want.found !== found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (want.ch !== ch) begin
        $error("ch_res: expected %02h, got %02h", want.ch, ch);
        errors++;
      end
      if (want.last !== last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = OP_ADD;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [0:0] m_tuser;
  logic       m_tlast;

  history_scoreboard sb;
  logic [7:0]        cur_line[$];
  bit                calm = 1'b0;
  int                n_sent = 0;
  int                hold_cnt = 0;
  int                cycles = 0;

  line_history_ring #(
    .HISTORY_DEPTH(HIST),
    .LINE_BYTES   (LINE)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'hFF;
    if (r < 16) return 8'h01;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void make_line();
    int n, r;
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 4);
    else if (r < 93) n = $urandom_range(5, 20);
    else if (r < 97) n = $urandom_range(62, 63);
    else n = $urandom_range(64, 66);
    cur_line.delete();
    repeat (n) cur_line.push_back(rand_char());
  endfunction

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin : rx_side
    int g;
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tuser[0], m_tdata, m_tlast);
    if (calm) begin
      m_tready <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (m_tready) begin
      g = pick_gap();
      if (g > 0) begin
        m_tready <= 1'b0;
        hold_cnt <= g - 1;
      end else begin
        hold_cnt <= $urandom_range(0, 6);
      end
    end else begin
      m_tready <= 1'b1;
      hold_cnt <= $urandom_range(0, 7);
    end
  end

  task automatic send_beat(input op_t op, input logic [7:0] ch);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_beat(op, ch);
    n_sent++;
  endtask

  task automatic send_line();
    foreach (cur_line[i]) send_beat(OP_ADD, cur_line[i]);
    send_beat(OP_ADD, 8'h00);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic walk(input op_t op, input int n);
    repeat (n) send_beat(op, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int r;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, empty line, duplicate, both ends of the walk
    send_beat(OP_OLDER, 8'h00);
    send_beat(OP_NEWER, 8'hFF);
    send_beat(OP_RESET, 8'hFF);
    send_beat(OP_ADD, 8'h00);
    cur_line = '{8'h01, 8'hFF};
    send_line();
    send_line();
    cur_line = '{8'hAA, 8'h55};
    send_line();
    send_beat(OP_OLDER, 8'h55);
    send_beat(OP_OLDER, 8'hAA);
    send_beat(OP_OLDER, 8'h00);
    send_beat(OP_NEWER, 8'h01);
    send_beat(OP_NEWER, 8'h80);
    send_beat(OP_NEWER, 8'h7F);
    send_beat(OP_OLDER, 8'h00);
    send_beat(OP_RESET, 8'h00);
    send_beat(OP_NEWER, 8'hFF);
    wait_drain();

    // short distinct lines, enough to wrap the ring
    for (int i = 0; i < HIST + 1; i++) begin
      cur_line = '{8'(i + 16)};
      send_line();
    end

    // longest line that fits, then its duplicate
    cur_line.delete();
    repeat (LINE - 1) cur_line.push_back(rand_char());
    send_line();
    send_line();
    send_beat(OP_OLDER, 8'h3C);
    send_beat(OP_RESET, 8'hC3);

    // random: mostly whole lines and walks, some noise
    while (n_sent < 265) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 4) calm = !calm;
      if (r < 45) begin
        make_line();
        send_line();
      end else if (r < 55) begin
        send_line();
      end else if (r < 59) begin
        send_beat(OP_ADD, 8'h00);
      end else if (r < 62) begin
        walk(OP_OLDER, sb.count + 2);
        walk(OP_NEWER, sb.count + 2);
      end else if (r < 84) begin
        repeat ($urandom_range(1, 6))
          walk(($urandom_range(0, 99) < 65) ? OP_OLDER : OP_NEWER, 1);
      end else if (r < 89) begin
        walk(OP_RESET, 1);
      end else if (r < 96) begin
        repeat ($urandom_range(1, 3))
          send_beat(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        wait_drain();
      end
    end

    wait_drain();
    calm = 1'b0;
    repeat (300) @(posedge clk);
    $display("Sent %0d input beats, checked %0d result beats.", n_sent, sb.n_checked);
    $display("Stored %0d lines (ring wrapped), dropped %0d duplicates.",
             sb.n_lines, sb.n_dups);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
